### rtl/core/htr_pkg.sv
// Shared types and constants for the heater thermostat with hysteresis.
package htr_pkg;

    localparam int SAMPLE_DEPTH = 4;
    localparam int SAMPLE_W     = 10;
    localparam int POS_W        = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
    localparam int SUM_W        = SAMPLE_W + $clog2(SAMPLE_DEPTH + 1);
    localparam int HUM_W        = 10;
    localparam int TEMP_W       = 11;
    localparam int LEVEL_W      = 7;
    localparam int ACTION_W     = 2;
    localparam int CFG_ADDR_W   = 1;

    localparam int S_TDATA_W    = 24;
    localparam int M_TDATA_W    = 32;

    localparam logic [SAMPLE_W-1:0] HOT_LIMIT = SAMPLE_W'(800);

    // temperature = floor((TEMP_NUM - 160 * avg) / 111) for avg below HOT_LIMIT.
    localparam int TEMP_NUM_W   = 17;
    localparam logic [TEMP_NUM_W-1:0] TEMP_NUM = TEMP_NUM_W'(128052);
    localparam int RECIP_W      = 18;
    localparam logic [RECIP_W-1:0] TEMP_RECIP = RECIP_W'(151147);
    localparam int RECIP_SHIFT  = 24;

    localparam int HALF_DEG_16  = 8;
    localparam int HALF_PCT_10  = 5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_NTC  = 2'd0,
        ACT_HUM  = 2'd1,
        ACT_TICK = 2'd2
    } action_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TEMP_LEVEL = 1'b0,
        CFG_HUM_LEVEL  = 1'b1
    } cfg_addr_t;

    typedef struct packed {
        logic                push;
        logic [SAMPLE_W-1:0] sample;
    } ring_ctrl_t;

endpackage

### rtl/core/htr_ring.sv
// Thermistor sample ring with priming fill and running average of its entries.
module htr_ring (
    input  logic                          clk,
    input  logic                          rst_n,
    input  htr_pkg::ring_ctrl_t           ctrl,
    output logic [htr_pkg::SAMPLE_W-1:0]  avg_next,
    output logic                          primed_next
);

    logic [htr_pkg::SAMPLE_W-1:0] ring_reg  [htr_pkg::SAMPLE_DEPTH];
    logic [htr_pkg::SAMPLE_W-1:0] ring_next [htr_pkg::SAMPLE_DEPTH];
    logic [htr_pkg::POS_W-1:0]    pos_reg;
    logic [htr_pkg::POS_W-1:0]    pos_next;
    logic                         primed_reg;
    logic [htr_pkg::SUM_W-1:0]    sum;

    always_comb
    begin
        ring_next   = ring_reg;
        pos_next    = pos_reg;
        primed_next = primed_reg;
        if (ctrl.push)
        begin
            if (!primed_reg)
            begin
                for (int i = 0; i < htr_pkg::SAMPLE_DEPTH; i++)
                begin
                    ring_next[i] = ctrl.sample;
                end
                pos_next    = '0;
                primed_next = 1'b1;
            end
            else
            begin
                ring_next[pos_reg] = ctrl.sample;
                if (pos_reg == htr_pkg::POS_W'(htr_pkg::SAMPLE_DEPTH - 1))
                begin
                    pos_next = '0;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < htr_pkg::SAMPLE_DEPTH; i++)
        begin
            sum = sum + htr_pkg::SUM_W'(ring_next[i]);
        end
    end

    assign avg_next = primed_next
                    ? htr_pkg::SAMPLE_W'(sum / htr_pkg::SAMPLE_DEPTH)
                    : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            primed_reg <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            primed_reg <= primed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ring_reg <= ring_next;
    end

endmodule

### rtl/core/htr_temp_conv.sv
// Conversion of the averaged thermistor sample to temperature in 1/16 degC.
module htr_temp_conv (
    input  logic                         primed,
    input  logic [htr_pkg::SAMPLE_W-1:0] avg,
    output logic [htr_pkg::TEMP_W-1:0]   temperature
);

    localparam int PROD_W = htr_pkg::TEMP_NUM_W + htr_pkg::RECIP_W;

    logic [htr_pkg::TEMP_NUM_W-1:0] avg_ext;
    logic [htr_pkg::TEMP_NUM_W-1:0] num;
    logic [PROD_W-1:0]              prod;

    // The slope of 160 is built from two shifts; the division by 111 is a
    // reciprocal multiply that is exact over the whole numerator range.
    assign avg_ext = htr_pkg::TEMP_NUM_W'(avg);
    assign num     = htr_pkg::TEMP_NUM - (avg_ext << 7) - (avg_ext << 5);
    assign prod    = PROD_W'(num) * PROD_W'(htr_pkg::TEMP_RECIP);

    assign temperature = (!primed || (avg >= htr_pkg::HOT_LIMIT))
                       ? '0
                       : prod[htr_pkg::RECIP_SHIFT +: htr_pkg::TEMP_W];

endmodule

### rtl/core/heater_thermostat_hysteresis.sv
// Top level of the heater thermostat with temperature and humidity hysteresis.
// A request is registered at the input, and its result is registered in the result register
// once the output register is free or its result is being taken, and is presented from there.
// Throughput: one request per cycle while the sink keeps m_tready high; the input and result
// registers let a new request in while a finished result waits for the sink.
// Reset clears the flags, the triac drive and the ring fill state, and sets the levels to 15 and 80.
module heater_thermostat_hysteresis (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [htr_pkg::S_TDATA_W-1:0]     s_tdata,   // adc_sample, humidity
    input  logic [htr_pkg::ACTION_W-1:0]      s_tuser,   // action
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // triac_on, triac_changed, avg_sample, temperature, too_cold, too_humid
    output logic [htr_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                              cfg_we,
    input  logic [htr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [htr_pkg::LEVEL_W-1:0]       cfg_wdata
);

    localparam int RES_W = 2 + htr_pkg::SAMPLE_W + htr_pkg::TEMP_W + 2;

    logic                            in_vld_reg;
    logic [htr_pkg::ACTION_W-1:0]    action_reg;
    logic [htr_pkg::SAMPLE_W-1:0]    sample_reg;
    logic [htr_pkg::HUM_W-1:0]       hum_reg;

    logic [htr_pkg::LEVEL_W-1:0]     temp_level_reg;
    logic [htr_pkg::LEVEL_W-1:0]     hum_level_reg;

    logic                            cold_reg;
    logic                            cold_next;
    logic                            humid_reg;
    logic                            humid_next;
    logic                            triac_reg;
    logic                            triac_next;
    logic                            changed;

    logic                            out_vld_reg;
    logic [RES_W-1:0]                res_reg;

    logic                            fire;
    htr_pkg::ring_ctrl_t             ring_ctrl;
    logic [htr_pkg::SAMPLE_W-1:0]    avg_next;
    logic                            ring_primed;
    logic [htr_pkg::TEMP_W-1:0]      temp_next;
    logic [12:0]                     temp_ext;
    logic [12:0]                     temp_lvl16;
    logic [11:0]                     hum_ext;
    logic [11:0]                     hum_lvl10;

    assign fire     = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || fire;

    assign ring_ctrl.push   = fire && (action_reg == htr_pkg::ACT_NTC);
    assign ring_ctrl.sample = sample_reg;

    htr_ring u_ring (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ring_ctrl),
        .avg_next    (avg_next),
        .primed_next (ring_primed)
    );

    htr_temp_conv u_conv (
        .primed      (ring_primed),
        .avg         (avg_next),
        .temperature (temp_next)
    );

    assign temp_ext   = 13'(temp_next);
    assign temp_lvl16 = 13'(temp_level_reg) << 4;
    assign hum_ext    = 12'(hum_reg);
    assign hum_lvl10  = (12'(hum_level_reg) << 3) + (12'(hum_level_reg) << 1);

    always_comb
    begin
        cold_next  = cold_reg;
        humid_next = humid_reg;
        triac_next = triac_reg;
        changed    = 1'b0;
        case (action_reg)
            htr_pkg::ACT_NTC:
            begin
                if (temp_ext + 13'(htr_pkg::HALF_DEG_16) < temp_lvl16)
                begin
                    cold_next = 1'b1;
                end
                else if (temp_ext > temp_lvl16 + 13'(htr_pkg::HALF_DEG_16))
                begin
                    cold_next = 1'b0;
                end
            end
            htr_pkg::ACT_HUM:
            begin
                if (hum_ext > hum_lvl10 + 12'(htr_pkg::HALF_PCT_10))
                begin
                    humid_next = 1'b1;
                end
                else if (hum_ext + 12'(htr_pkg::HALF_PCT_10) < hum_lvl10)
                begin
                    humid_next = 1'b0;
                end
            end
            htr_pkg::ACT_TICK:
            begin
                triac_next = !(cold_reg || humid_reg);
                changed    = triac_next != triac_reg;
            end
            default:
            begin
                changed = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
            cold_reg       <= 1'b0;
            humid_reg      <= 1'b0;
            triac_reg      <= 1'b0;
            temp_level_reg <= htr_pkg::LEVEL_W'(15);
            hum_level_reg  <= htr_pkg::LEVEL_W'(80);
        end
        else
        begin
            if (s_tready)
            begin
                in_vld_reg <= s_tvalid;
            end
            if (fire)
            begin
                out_vld_reg <= 1'b1;
                cold_reg    <= cold_next;
                humid_reg   <= humid_next;
                triac_reg   <= triac_next;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_addr)
                    htr_pkg::CFG_TEMP_LEVEL: temp_level_reg <= cfg_wdata;
                    htr_pkg::CFG_HUM_LEVEL:  hum_level_reg  <= cfg_wdata;
                    default:                 hum_level_reg  <= hum_level_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            action_reg <= s_tuser;
            sample_reg <= s_tdata[htr_pkg::SAMPLE_W-1:0];
            hum_reg    <= s_tdata[htr_pkg::SAMPLE_W +: htr_pkg::HUM_W];
        end
        if (fire)
        begin
            res_reg <= {humid_next, cold_next, temp_next, avg_next, changed, triac_next};
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = htr_pkg::M_TDATA_W'(res_reg);

endmodule

### rtl/core/htr_checker.sv
// Port-level checks for the heater thermostat and their binding to the top level.
module htr_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [htr_pkg::M_TDATA_W-1:0] m_tdata
);

    logic                         last_triac_reg;
    logic                         out_acc;
    logic [htr_pkg::SAMPLE_W-1:0] avg;
    logic [htr_pkg::TEMP_W-1:0]   temp;

    assign out_acc = m_tvalid && m_tready;
    assign avg     = m_tdata[2 +: htr_pkg::SAMPLE_W];
    assign temp    = m_tdata[2 + htr_pkg::SAMPLE_W +: htr_pkg::TEMP_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_triac_reg <= 1'b0;
        end
        else if (out_acc)
        begin
            last_triac_reg <= m_tdata[0];
        end
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_hot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (avg >= htr_pkg::HOT_LIMIT) |-> temp == '0)
        else $error("temperature not zero above the hot limit");

    a_cool_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (avg != '0) && (avg < htr_pkg::HOT_LIMIT)
        |-> (temp != '0) && (temp <= htr_pkg::TEMP_W'(1153)))
        else $error("temperature out of range for average");

    a_change_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> ((m_tdata[0] != last_triac_reg) == m_tdata[1]))
        else $error("triac change flag disagrees with drive history");

endmodule

bind heater_thermostat_hysteresis htr_checker u_htr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
